FILE: hdl/session_time_accounting_table_defines.svh
// Assertion macros shared by the session time accounting table RTL.
// Included by the top level; relies on the clock and reset port names.
`ifndef SESSION_TIME_ACCOUNTING_TABLE_DEFINES_SVH
`define SESSION_TIME_ACCOUNTING_TABLE_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define STA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define STA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/sta_pkg.sv
// Types and constants of the session time accounting table.
// No dependencies; used by sta_cell and the top level.
package sta_pkg;

   localparam int unsigned ID_W    = 32;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned TOTAL_W = 32;
   localparam int unsigned SLOT_W  = 6;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_NEW      = 3'd0,
      STATUS_ACCEPTED = 3'd1,
      STATUS_OUTORDER = 3'd2,
      STATUS_IGNORED  = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   // One event travelling along the cell row, together with its result so far.
   typedef struct packed {
      logic                 valid;
      logic                 done;
      logic [ID_W-1:0]      user_id;
      logic [TIME_W-1:0]    event_time;
      logic                 is_connect;
      status_type           status;
      logic [TOTAL_W-1:0]   total_time;
      logic                 long_session;
      logic [SLOT_W-1:0]    slot_index;
   } token_type;

endpackage

FILE: hdl/session_time_accounting_table.sv
// Session time accounting table: a row of TABLE_ENTRIES cells, one per table entry. Every
// event enters cell 0 and moves one cell per cycle while the row advances; the cell that
// holds its id, or the first free cell, updates itself and fills in the result. The event
// passes through every cell register and then the result register, and a new event is
// accepted every cycle while the result side keeps up. Events for the same id stay in order
// because they follow one another along the row. No clearing pass is needed after reset.
// Depends on sta_pkg, sta_cell and session_time_accounting_table_defines.svh.
`include "session_time_accounting_table_defines.svh"

module session_time_accounting_table #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Event items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] user_id, [63:32] event_time
   input  logic        req_tuser,   // [0] is_connect
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] status, [34:3] total_time,
                                    // [35] long_session, [41:36] slot_index, [47:42] zero
   // Long session limit register.
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   logic [sta_pkg::TIME_W-1:0]   limit_ff;
   logic                         advance;
   sta_pkg::token_type           head_w;
   sta_pkg::token_type           chain_w [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0]     entry_valid_w;
   sta_pkg::token_type           tail_w;
   logic                         rsp_valid_ff;
   logic [47:0]                  rsp_data_ff;
   logic                         rsp_accepted_w;

   // Limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 32'd86400;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // The whole row moves when the result register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Incoming item; an id of zero reads as ignored, any other as table full until a cell claims it.
   always_comb begin
      head_w.valid        = req_tvalid;
      head_w.user_id      = req_tdata[31:0];
      head_w.event_time   = req_tdata[63:32];
      head_w.is_connect   = req_tuser;
      head_w.done         = (req_tdata[31:0] == '0);
      head_w.status       = (req_tdata[31:0] == '0) ? sta_pkg::STATUS_IGNORED
                                                    : sta_pkg::STATUS_FULL;
      head_w.total_time   = '0;
      head_w.long_session = 1'b0;
      head_w.slot_index   = '0;
   end

   assign chain_w[0] = head_w;

   // Row of table cells.
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      sta_cell #(
         .SLOT (sta_pkg::SLOT_W'(g))
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .limit       (limit_ff),
         .in_token    (chain_w[g]),
         .out_token   (chain_w[g+1]),
         .entry_valid (entry_valid_w[g])
      );
   end

   assign tail_w = chain_w[TABLE_ENTRIES];

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail_w.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {6'd0, tail_w.slot_index, tail_w.long_session,
                         tail_w.total_time, tail_w.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status of the waiting result, for the checks below.
   assign rsp_accepted_w = (rsp_data_ff[2:0] == sta_pkg::STATUS_ACCEPTED);

   // An item leaves the row unclaimed only when every entry is in use.
   `STA_ASSERT_SAME(a_full_only, tail_w.valid && !tail_w.done, &entry_valid_w, "free entry skipped")
   // Entries fill from slot zero upwards with no gaps.
   `STA_ASSERT_SAME(a_fill_order, 1'b1, (entry_valid_w & (entry_valid_w + 1'b1)) == '0, "gap")
   // A stalled row leaves the table untouched.
   `STA_ASSERT_NEXT(a_stall_freezes, !advance, $stable(entry_valid_w), "table changed in stall")
   // A long session is only reported on an accepted event.
   `STA_ASSERT_SAME(a_long_accepted, rsp_valid_ff && rsp_data_ff[35], rsp_accepted_w, "bad long flag")

endmodule

FILE: hdl/sta_cell.sv
// One table entry of the session time accounting table and its pipeline stage.
// Depends on sta_pkg for the token type and status codes.
module sta_cell #(
   parameter logic [sta_pkg::SLOT_W-1:0] SLOT = '0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [sta_pkg::TIME_W-1:0]   limit,
   input  sta_pkg::token_type           in_token,
   output sta_pkg::token_type           out_token,
   output logic                         entry_valid
);

   logic                          valid_ff, valid_in;
   logic [sta_pkg::ID_W-1:0]      user_ff, user_in;
   logic                          conn_ff, conn_in;
   logic [sta_pkg::TIME_W-1:0]    last_ff, last_in;
   logic [sta_pkg::TOTAL_W-1:0]   total_ff, total_in;
   sta_pkg::token_type            tok_ff, tok_in;

   logic                          hit;
   logic                          claim;
   logic [sta_pkg::TIME_W:0]      diff;
   logic [sta_pkg::TIME_W-1:0]    delta;
   logic [sta_pkg::TOTAL_W:0]     sum;
   logic [sta_pkg::TOTAL_W-1:0]   total_sat;

   // Elapsed time, clamped at zero, and the saturated new total.
   always_comb begin
      diff      = {1'b0, in_token.event_time} - {1'b0, last_ff};
      delta     = diff[sta_pkg::TIME_W] ? '0 : diff[sta_pkg::TIME_W-1:0];
      sum       = {1'b0, total_ff} + {1'b0, delta};
      total_sat = sum[sta_pkg::TOTAL_W] ? '1 : sum[sta_pkg::TOTAL_W-1:0];
   end

   // This entry takes the item if it holds the id, or if it is the first free entry.
   assign hit   = valid_ff && (user_ff == in_token.user_id);
   assign claim = in_token.valid && !in_token.done && (hit || !valid_ff);

   // Entry update and the item's result as it leaves this cell.
   always_comb begin
      valid_in = valid_ff;
      user_in  = user_ff;
      conn_in  = conn_ff;
      last_in  = last_ff;
      total_in = total_ff;
      tok_in   = in_token;
      if (claim) begin
         tok_in.done       = 1'b1;
         tok_in.slot_index = SLOT;
         if (!valid_ff) begin
            valid_in                = 1'b1;
            user_in                 = in_token.user_id;
            conn_in                 = in_token.is_connect;
            last_in                 = in_token.event_time;
            total_in                = '0;
            tok_in.status           = sta_pkg::STATUS_NEW;
            tok_in.total_time       = '0;
            tok_in.long_session     = 1'b0;
         end else if (conn_ff == in_token.is_connect) begin
            tok_in.status           = sta_pkg::STATUS_OUTORDER;
            tok_in.total_time       = total_ff;
            tok_in.long_session     = 1'b0;
         end else if (in_token.is_connect) begin
            conn_in                 = 1'b1;
            last_in                 = in_token.event_time;
            tok_in.status           = sta_pkg::STATUS_ACCEPTED;
            tok_in.total_time       = total_ff;
            tok_in.long_session     = 1'b0;
         end else begin
            conn_in                 = 1'b0;
            total_in                = total_sat;
            tok_in.status           = sta_pkg::STATUS_ACCEPTED;
            tok_in.total_time       = total_sat;
            tok_in.long_session     = (delta > limit);
         end
      end
   end

   // Entry state and the stage's item; only the valid flags are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         user_ff  <= user_in;
         conn_ff  <= conn_in;
         last_ff  <= last_in;
         total_ff <= total_in;
         tok_ff   <= tok_in;
      end
   end

   assign out_token   = tok_ff;
   assign entry_valid = valid_ff;

endmodule

FILE: sim/session_time_accounting_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the session time accounting table: directed and random event streams.
// Depends on sta_pkg and the session_time_accounting_table RTL only.
module session_time_accounting_table_test;

   localparam int unsigned ENTRIES       = 64;
   localparam int unsigned LATENCY       = ENTRIES + 1;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam logic [31:0] DEFAULT_LIMIT = 32'd86400;
   localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

   // What one event should produce on the result side.
   typedef struct packed {
      sta_pkg::status_type status;
      logic [31:0]         total;
      logic                long_flag;
      logic [5:0]          slot;
   } session_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] user_id, [63:32] event_time
   logic        req_tuser  = 1'b0; // [0] is_connect
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [2:0] status, [34:3] total_time,
                                   // [35] long_session, [41:36] slot_index
   logic        csr_we     = 1'b0;
   logic [31:0] csr_wdata  = '0;

   // Our own copy of the accounting table.
   logic        slot_in_use [ENTRIES] = '{default: 1'b0};
   logic [31:0] slot_owner  [ENTRIES] = '{default: '0};
   logic        slot_online [ENTRIES] = '{default: 1'b0};
   logic [31:0] slot_since  [ENTRIES] = '{default: '0};
   logic [31:0] slot_accum  [ENTRIES] = '{default: '0};
   int unsigned slots_taken   = 0;
   logic [31:0] session_limit = DEFAULT_LIMIT;

   session_result_type pending_results[$];
   int  error_count     = 0;
   int  quiet_cycles    = 0;
   int  ready_pause     = 0;
   bit  idle_bursts_on  = 1'b1;

   session_time_accounting_table #(.TABLE_ENTRIES(ENTRIES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Slot holding the id, or -1 when the id has no entry yet.
   function automatic int find_owner(input logic [31:0] uid);
      for (int k = 0; k < ENTRIES; k++)
         if (slot_in_use[k] && slot_owner[k] == uid) return k;
      return -1;
   endfunction

   // Applies one event to the table copy and returns the result it should give.
   function automatic session_result_type account_event(input logic [31:0] uid,
                                                        input logic [31:0] t,
                                                        input logic conn);
      session_result_type r;
      int                 s;
      logic [31:0]        delta;
      logic [32:0]        sum;
      r = '{status: sta_pkg::STATUS_IGNORED, total: '0, long_flag: 1'b0, slot: '0};
      if (uid == '0) return r;
      s = find_owner(uid);
      if (s < 0) begin
         if (slots_taken >= ENTRIES) begin
            r.status = sta_pkg::STATUS_FULL;
            return r;
         end
         s = slots_taken;
         slot_in_use[s] = 1'b1;
         slot_owner[s]  = uid;
         slot_online[s] = conn;
         slot_since[s]  = t;
         slot_accum[s]  = '0;
         slots_taken++;
         r.status = sta_pkg::STATUS_NEW;
         r.slot   = 6'(s);
         return r;
      end
      r.slot  = 6'(s);
      r.total = slot_accum[s];
      // A repeat of the current state is dropped and leaves the entry alone.
      if (slot_online[s] == conn) begin
         r.status = sta_pkg::STATUS_OUTORDER;
         return r;
      end
      r.status       = sta_pkg::STATUS_ACCEPTED;
      slot_online[s] = conn;
      if (conn) begin
         slot_since[s] = t;
         return r;
      end
      // A disconnect before the last connect counts as no time; the total saturates.
      delta         = (t >= slot_since[s]) ? t - slot_since[s] : '0;
      sum           = {1'b0, slot_accum[s]} + {1'b0, delta};
      slot_accum[s] = sum[32] ? TIME_MAX : sum[31:0];
      r.total       = slot_accum[s];
      r.long_flag   = (delta > session_limit);
      return r;
   endfunction

   // Sends one event item, sometimes after an idle burst, and records its expected result.
   task automatic send_event(input logic [31:0] uid, input logic [31:0] t, input logic conn);
      int gap;
      if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, uid};
      req_tuser  <= conn;
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), account_event(uid, t, conn));
   endtask

   // Holds the sender back until every expected result has come out.
   task automatic await_results;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_session_limit(input logic [31:0] value);
      await_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we        <= 1'b0;
      session_limit  = value;
   endtask

   // An id that has no entry, so the event would need a fresh slot.
   function automatic logic [31:0] unknown_id();
      logic [31:0] uid;
      do uid = $urandom; while (uid == '0 || find_owner(uid) >= 0);
      return uid;
   endfunction

   // One random event: mostly a proper connect/disconnect alternation on a known id,
   // with repeats, wild times, unknown ids and ignored rows mixed in.
   task automatic send_random_event(output bit counted);
      int          roll;
      int          k;
      logic [31:0] uid;
      logic [31:0] t;
      logic [31:0] span;
      logic        conn;
      roll    = $urandom_range(0, 99);
      counted = 1'b1;
      if (roll < 4) begin
         send_event('0, $urandom, 1'($urandom_range(0, 1)));
         counted = 1'b0;
      end else if (roll < 8 || slots_taken == 0) begin
         send_event(unknown_id(), $urandom, 1'($urandom_range(0, 1)));
      end else begin
         k    = $urandom_range(0, slots_taken - 1);
         uid  = slot_owner[k];
         conn = !slot_online[k];
         if (roll < 16) conn = ~conn;
         if (session_limit > 32'h0FFF_FFFF) span = $urandom;
         else span = $urandom_range(0, session_limit * 2 + 2);
         if (conn) t = $urandom_range(0, 32'hF000_0000);
         else if (roll < 22) t = $urandom;
         else t = slot_since[k] + span;
         send_event(uid, t, conn);
      end
   endtask

   // Ignored rows, state repeats, saturation, negative time and the limit boundary.
   task automatic test_directed_cases;
      send_event('0, TIME_MAX, 1'b1);
      send_event('0, '0, 1'b0);
      send_event(32'hFFFF_FFFF, '0, 1'b1);
      send_event(32'hFFFF_FFFF, 32'd5, 1'b1);
      send_event(32'hFFFF_FFFF, TIME_MAX, 1'b0);
      send_event(32'hFFFF_FFFF, 32'd7, 1'b0);
      send_event(32'hFFFF_FFFF, 32'd100, 1'b1);
      send_event(32'hFFFF_FFFF, 32'd200, 1'b0);
      send_event(32'h0000_0001, 32'h10, 1'b1);
      send_event(32'h0000_0001, TIME_MAX, 1'b0);
      send_event(32'h0000_0001, '0, 1'b1);
      send_event(32'h0000_0001, 32'h100, 1'b0);
      send_event(32'h8000_0000, 32'd1000, 1'b1);
      send_event(32'h8000_0000, 32'd999, 1'b0);
      send_event(32'h8000_0000, '0, 1'b1);
      send_event(32'h8000_0000, DEFAULT_LIMIT, 1'b0);
      send_event(32'h8000_0000, 32'd1000000, 1'b1);
      send_event(32'h8000_0000, 32'd1000000 + DEFAULT_LIMIT + 1, 1'b0);
      send_event(32'h5A5A_A5A5, 32'h1234_5678, 1'b0);
      send_event(32'h5A5A_A5A5, 32'h1234_5679, 1'b0);
      send_event(32'h5A5A_A5A5, 32'h2000_0000, 1'b1);
      send_event('0, 32'h5555_5555, 1'b1);
   endtask

   // Long session flag with the limit at zero, at its maximum and at a random value.
   task automatic test_limit_extremes;
      write_session_limit('0);
      send_event(32'h0000_0100, 32'd500, 1'b1);
      send_event(32'h0000_0100, 32'd500, 1'b0);
      send_event(32'h0000_0100, 32'd600, 1'b1);
      send_event(32'h0000_0100, 32'd601, 1'b0);
      write_session_limit(TIME_MAX);
      send_event(32'h7FFF_FFFE, '0, 1'b1);
      send_event(32'h7FFF_FFFE, TIME_MAX, 1'b0);
      write_session_limit($urandom_range(1, 200000));
      send_event(32'h0000_0100, 32'd1000, 1'b1);
      send_event(32'h0000_0100, 32'd1000 + session_limit + 1, 1'b0);
      send_event(32'h0000_0100, 32'd2000, 1'b1);
      send_event(32'h0000_0100, 32'd2000 + session_limit, 1'b0);
   endtask

   // Fills every slot with fresh ids, then offers more new ids to a full table.
   task automatic test_table_fill;
      while (slots_taken < ENTRIES)
         send_event(unknown_id(), $urandom, 1'($urandom_range(0, 1)));
      repeat (4) send_event(unknown_id(), $urandom, 1'($urandom_range(0, 1)));
   endtask

   // Random sessions in rounds; each round starts with the sender waiting for every
   // result to come back and a new limit being written.
   task automatic test_random_sessions;
      logic [31:0] limits [4];
      int          sent;
      bit          counted;
      limits = '{DEFAULT_LIMIT, $urandom_range(0, 1000), $urandom_range(50000, 150000),
                 $urandom};
      foreach (limits[r]) begin
         write_session_limit(limits[r]);
         sent = 0;
         while (sent < 240) begin
            send_random_event(counted);
            if (counted) sent++;
         end
      end
   endtask

   // Back-to-back items with both sides always ready.
   task automatic test_quiet_tail;
      int sent;
      bit counted;
      idle_bursts_on = 1'b0;
      sent = 0;
      while (sent < 100) begin
         send_random_event(counted);
         if (counted) sent++;
      end
   endtask

   // Result side back-pressure in random bursts, while idle bursts are enabled.
   always @(posedge clock) begin
      if (ready_pause > 0) begin
         ready_pause--;
         rsp_tready <= 1'b0;
      end else if (idle_bursts_on && $urandom_range(0, 9) == 0) begin
         ready_pause = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Every result item is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      session_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_tdata[2:0]));
            compare_field("total_time", want.total, rsp_tdata[34:3]);
            compare_field("long_session", 32'(want.long_flag), 32'(rsp_tdata[35]));
            compare_field("slot_index", 32'(want.slot), 32'(rsp_tdata[41:36]));
         end
      end
   end

   // Ends the run when neither side has moved an item for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_limit_extremes();
      test_table_fill();
      test_random_sessions();
      test_quiet_tail();
      await_results();
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: session_time_accounting_table.f
+incdir+hdl
hdl/sta_pkg.sv
hdl/sta_cell.sv
hdl/session_time_accounting_table.sv
sim/session_time_accounting_table_test.sv
